// ===== hdl/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types, constants and helpers for the texture page quad splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

	// page geometry; PAGE_TEXELS must be a power of two no larger than 256
	localparam int PAGE_TEXELS = 256;
	localparam int MAX_QUADS   = 17;
	localparam int CNT_W       = $clog2(MAX_QUADS);

	localparam logic [8:0] PG_SPAN    = 9'(PAGE_TEXELS);
	localparam logic [7:0] U_MASK     = 8'(PAGE_TEXELS - 1);
	localparam logic [8:0] U_CLAMP_AT = 9'd256;
	localparam logic [7:0] U_MAX      = 8'd255;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_QUADS - 1);

	// field widths
	localparam int SCR_W_W = 10;
	localparam int SCR_H_W = 9;
	localparam int PIX_W   = 12;
	localparam int X_W     = 12;

	// color modes
	localparam logic [1:0] MODE_4BIT  = 2'd0;
	localparam logic [1:0] MODE_8BIT  = 2'd1;
	localparam logic [1:0] MODE_16BIT = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'd0;
	localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'd1;

	localparam logic [SCR_W_W-1:0] SCREEN_WIDTH_RST  = 10'd320;
	localparam logic [SCR_H_W-1:0] SCREEN_HEIGHT_RST = 9'd240;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN
	} tpq_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
	} tpq_cmd_t;

	typedef struct packed {
		logic zero_width;
		logic last;
	} tpq_sts_t;

	typedef struct packed {
		logic [1:0] color_mode;
		logic [9:0] width_words;
		logic [8:0] image_height;
		logic [9:0] vram_x;
		logic [8:0] vram_y;
		logic       has_palette;
		logic [7:0] shade_level;
	} tpq_item_t;

	typedef struct packed {
		logic signed [11:0] x_left;
		logic signed [11:0] x_right;
		logic [8:0]         y_top;
		logic [9:0]         y_bottom;
		logic [7:0]         u_left;
		logic [7:0]         u_right;
		logic [7:0]         v_top;
		logic [7:0]         v_bottom;
		logic [10:0]        page_column;
		logic [7:0]         shade_out;
		logic               palette_enable;
		logic               last_quad;
	} tpq_quad_t;

	// texel-per-word shift: 16-bit x1, 8-bit x2, 4-bit x4
	function automatic logic [1:0] tpq_shift(input logic [1:0] mode);
		logic [1:0] s;
		case (mode)
			MODE_16BIT: s = 2'd0;
			MODE_8BIT:  s = 2'd1;
			MODE_4BIT:  s = 2'd2;
			default:    s = 2'd2;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tpq_if.sv =====
// ----------------------------------------------------------------------------
// tpq_if
// Channel interfaces: image request, quad result and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] color_mode;
	logic [9:0] width_words;
	logic [8:0] image_height;
	logic [9:0] vram_x;
	logic [8:0] vram_y;
	logic       has_palette;
	logic [7:0] shade_level;

	modport source (output valid, color_mode, width_words, image_height, vram_x,
		vram_y, has_palette, shade_level, input ready);
	modport sink (input valid, color_mode, width_words, image_height, vram_x,
		vram_y, has_palette, shade_level, output ready);
endinterface

interface tpq_quad_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] x_left;
	logic signed [11:0] x_right;
	logic [8:0]         y_top;
	logic [9:0]         y_bottom;
	logic [7:0]         u_left;
	logic [7:0]         u_right;
	logic [7:0]         v_top;
	logic [7:0]         v_bottom;
	logic [10:0]        page_column;
	logic [7:0]         shade_out;
	logic               palette_enable;
	logic               last_quad;

	modport source (output valid, x_left, x_right, y_top, y_bottom, u_left, u_right,
		v_top, v_bottom, page_column, shade_out, palette_enable, last_quad,
		input ready);
	modport sink (input valid, x_left, x_right, y_top, y_bottom, u_left, u_right,
		v_top, v_bottom, page_column, shade_out, palette_enable, last_quad,
		output ready);
endinterface

interface tpq_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/texture_page_quad_splitter_unit.sv =====
// Requests latch in IDLE, set up in PREP and, unless zero-width, walk in RUN.
// One quad per cycle from the page walker while the result register is free;
// an image of N quads (N <= 17) holds the request side for PREP and N steps.
// The request side reopens while the final quad still waits in the result register.
// Reset: arst_n clears the sequencer and result valid, screen size to 320 x 240.
// ----------------------------------------------------------------------------
// texture_page_quad_splitter_unit
// Centers an image on screen and cuts it into textured quads at page edges.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_page_quad_splitter_unit (
	input wire logic clk,
	input wire logic arst_n,
	tpq_req_if.sink    req,
	tpq_quad_if.source quad,
	tpq_cfg_if.sink    cfg
);
	import tpq_pkg::*;

	tpq_item_t item;
	tpq_quad_t quad_d;
	tpq_cmd_t  cmd;
	tpq_sts_t  sts;

	always_comb begin
		item.color_mode   = req.color_mode;
		item.width_words  = req.width_words;
		item.image_height = req.image_height;
		item.vram_x       = req.vram_x;
		item.vram_y       = req.vram_y;
		item.has_palette  = req.has_palette;
		item.shade_level  = req.shade_level;
	end

	tpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (quad.valid),
		.out_ready (quad.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.quad   (quad_d)
	);

	assign quad.x_left         = quad_d.x_left;
	assign quad.x_right        = quad_d.x_right;
	assign quad.y_top          = quad_d.y_top;
	assign quad.y_bottom       = quad_d.y_bottom;
	assign quad.u_left         = quad_d.u_left;
	assign quad.u_right        = quad_d.u_right;
	assign quad.v_top          = quad_d.v_top;
	assign quad.v_bottom       = quad_d.v_bottom;
	assign quad.page_column    = quad_d.page_column;
	assign quad.shade_out      = quad_d.shade_out;
	assign quad.palette_enable = quad_d.palette_enable;
	assign quad.last_quad      = quad_d.last_quad;

`ifndef SYNTHESIS
	a_step_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!quad.valid || quad.ready))
		else $error("quad step with result register occupied");

	a_quads_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(quad.valid && quad.ready && !quad.last_quad) |=> quad.valid)
		else $error("gap inside an image's quad run");

	a_req_only_after_image: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !(quad.valid && !quad.last_quad))
		else $error("request taken while an image is still in flight");
`endif

endmodule

`default_nettype wire

// ===== hdl/tpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpq_ctrl
// Controller: sequences load, setup and per-quad steps; owns the result
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire tpq_pkg::tpq_sts_t sts,
	output tpq_pkg::tpq_cmd_t      cmd
);
	import tpq_pkg::*;

	tpq_state_t state_q, state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_PREP;
			end
			ST_PREP: begin
				state_nxt = sts.zero_width ? ST_IDLE : ST_RUN;
			end
			ST_RUN: begin
				if (slot_free && sts.last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_RUN: begin
				cmd.step = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/tpq_dp.sv =====
// ----------------------------------------------------------------------------
// tpq_dp
// Datapath: screen registers, image setup (centering, clamp) and the page
// walker that emits one quad per step into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	tpq_cfg_if.sink                 cfg,
	input  wire tpq_pkg::tpq_item_t item,
	input  wire tpq_pkg::tpq_cmd_t  cmd,
	output tpq_pkg::tpq_sts_t       sts,
	output tpq_pkg::tpq_quad_t      quad
);
	import tpq_pkg::*;

	logic [SCR_W_W-1:0] sw_q;
	logic [SCR_H_W-1:0] sh_q;

	// latched request
	logic [1:0] shift_q;
	logic [9:0] wwords_q;
	logic [8:0] hgt_q;
	logic [9:0] vx_q;
	logic [8:0] vy_q;
	logic       pal_q;
	logic [7:0] shade_q;

	// walker state
	logic [X_W-1:0]   x_q;
	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] done_q;
	logic [8:0]       u_q;
	logic [CNT_W-1:0] cnt_q;
	logic [8:0]       yt_q;
	logic [9:0]       yb_q;
	logic [7:0]       vb_q;

	// setup
	logic [8:0]         h_clamp;
	logic [PIX_W-1:0]   pix_w;
	logic signed [12:0] diff_x;
	logic signed [12:0] off_x;
	logic [8:0]         off_y;
	logic [7:0]         u0;

	// step
	logic [8:0]       room;
	logic [8:0]       w;
	logic [8:0]       u_sum;
	logic [PIX_W-1:0] done_words;
	logic             last;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SCREEN_WIDTH_RST;
			sh_q <= SCREEN_HEIGHT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_SCREEN_WIDTH) sw_q <= cfg.data;
			if (cfg.index == CFG_SCREEN_HEIGHT) sh_q <= cfg.data[SCR_H_W-1:0];
		end
	end

	always_comb begin
		h_clamp = (hgt_q > sh_q) ? sh_q : hgt_q;
		pix_w   = {2'b00, wwords_q} << shift_q;
		diff_x  = $signed({3'b000, sw_q}) - $signed({1'b0, pix_w});
		// halve, rounding toward zero
		off_x   = (diff_x + $signed({12'd0, diff_x[12]})) >>> 1;
		off_y   = (sh_q - h_clamp) >> 1;
		u0      = ({2'b00, vx_q[5:0]} << shift_q) & U_MASK;
	end

	always_comb begin
		room       = PG_SPAN - u_q;
		w          = ({3'b000, room} > rem_q) ? rem_q[8:0] : room;
		u_sum      = u_q + w;
		done_words = done_q >> shift_q;
		last       = (rem_q == {3'b000, w}) || (cnt_q == LAST_IDX);
	end

	assign sts.zero_width = (wwords_q == 10'd0);
	assign sts.last       = last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q  <= tpq_shift(item.color_mode);
			wwords_q <= item.width_words;
			hgt_q    <= item.image_height;
			vx_q     <= item.vram_x;
			vy_q     <= item.vram_y;
			pal_q    <= item.has_palette;
			shade_q  <= item.shade_level;
		end
		if (cmd.prep) begin
			x_q    <= off_x[X_W-1:0];
			rem_q  <= pix_w;
			done_q <= '0;
			u_q    <= {1'b0, u0};
			cnt_q  <= '0;
			yt_q   <= off_y;
			yb_q   <= {1'b0, off_y} + {1'b0, h_clamp};
			vb_q   <= 8'(vy_q + h_clamp);
		end
		if (cmd.step) begin
			quad.x_left         <= $signed(x_q);
			quad.x_right        <= $signed(x_q + {3'b000, w});
			quad.y_top          <= yt_q;
			quad.y_bottom       <= yb_q;
			quad.u_left         <= u_q[7:0];
			quad.u_right        <= (u_sum >= U_CLAMP_AT) ? U_MAX : u_sum[7:0];
			quad.v_top          <= vy_q[7:0];
			quad.v_bottom       <= vb_q;
			quad.page_column    <= {1'b0, vx_q} + done_words[10:0];
			quad.shade_out      <= shade_q;
			quad.palette_enable <= pal_q;
			quad.last_quad      <= last;

			x_q    <= x_q + {3'b000, w};
			rem_q  <= rem_q - {3'b000, w};
			done_q <= done_q + {3'b000, w};
			u_q    <= (u_sum >= PG_SPAN) ? (u_sum - PG_SPAN) : u_sum;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
